[hdl/infix_to_postfix_converter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Infix to postfix converter assertion macros
// Shared concurrent assertion shorthands for the converter modules.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define I2P_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2p assertion failed");

// next-cycle implication, disabled during reset
`define I2P_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2p assertion failed");

`endif

[hdl/i2p_pkg.sv]
// ----------------------------------------------------------------------------
// i2p_pkg
// Types, character codes and operator helpers of the infix to postfix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package i2p_pkg;

  // default operator stack depth and queue sizing
  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_AW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

  // ascii characters
  localparam logic [7:0] CHR_HASH = 8'h23;
  localparam logic [7:0] CHR_LPAR = 8'h28;
  localparam logic [7:0] CHR_RPAR = 8'h29;
  localparam logic [7:0] CHR_MUL  = 8'h2A;
  localparam logic [7:0] CHR_ADD  = 8'h2B;
  localparam logic [7:0] CHR_SUB  = 8'h2D;
  localparam logic [7:0] CHR_DIV  = 8'h2F;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_NINE = 8'h39;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  // stacked operator codes
  typedef enum logic [2:0] {
    OPC_LPAR = 3'd0,
    OPC_MUL  = 3'd1,
    OPC_DIV  = 3'd2,
    OPC_ADD  = 3'd3,
    OPC_SUB  = 3'd4
  } opcode_e;

  // classified item kinds
  typedef enum logic [2:0] {
    KIND_DIGIT = 3'd0,
    KIND_LPAR  = 3'd1,
    KIND_RPAR  = 3'd2,
    KIND_OPER  = 3'd3,
    KIND_FIN   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] symbol;
    opcode_e    opcode;
  } item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic [1:0] error_code;
    logic       last;
  } result_t;

  // binding priority of a stacked code
  function automatic logic [2:0] op_prio(opcode_e op);
    logic [2:0] p;
    case (op)
      OPC_MUL, OPC_DIV: p = 3'd4;
      OPC_ADD, OPC_SUB: p = 3'd3;
      OPC_LPAR:         p = 3'd2;
      default:          p = 3'd0;
    endcase
    return p;
  endfunction

  // character emitted when a code is popped
  function automatic logic [7:0] op_char(opcode_e op);
    logic [7:0] c;
    case (op)
      OPC_LPAR: c = CHR_LPAR;
      OPC_MUL:  c = CHR_MUL;
      OPC_DIV:  c = CHR_DIV;
      OPC_ADD:  c = CHR_ADD;
      OPC_SUB:  c = CHR_SUB;
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/i2p_front.sv]
// ----------------------------------------------------------------------------
// i2p_front
// Accepts input beats, classifies the character and queues useful items.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_front import i2p_pkg::*; (
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       finish_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output item_t           q_item_o
);

  logic keep;

  // character decoder, unknown characters are dropped
  always_comb begin
    q_item_o.kind   = KIND_DIGIT;
    q_item_o.symbol = symbol_i;
    q_item_o.opcode = OPC_LPAR;
    keep            = 1'b1;
    if (finish_i) begin
      q_item_o.kind = KIND_FIN;
    end else if (symbol_i >= CHR_ZERO && symbol_i <= CHR_NINE) begin
      q_item_o.kind = KIND_DIGIT;
    end else begin
      unique case (symbol_i)
        CHR_LPAR: begin
          q_item_o.kind   = KIND_LPAR;
          q_item_o.opcode = OPC_LPAR;
        end
        CHR_RPAR: q_item_o.kind = KIND_RPAR;
        CHR_MUL: begin
          q_item_o.kind   = KIND_OPER;
          q_item_o.opcode = OPC_MUL;
        end
        CHR_DIV: begin
          q_item_o.kind   = KIND_OPER;
          q_item_o.opcode = OPC_DIV;
        end
        CHR_ADD: begin
          q_item_o.kind   = KIND_OPER;
          q_item_o.opcode = OPC_ADD;
        end
        CHR_SUB: begin
          q_item_o.kind   = KIND_OPER;
          q_item_o.opcode = OPC_SUB;
        end
        default: keep = 1'b0;
      endcase
    end
  end

  // beat handshake
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

`default_nettype wire

[hdl/i2p_fifo.sv]
// ----------------------------------------------------------------------------
// i2p_fifo
// Short item queue between the classifying front and the stack engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "infix_to_postfix_converter_unit_macros.svh"

module i2p_fifo import i2p_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output item_t      head_o
);

  item_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_q;
  logic [QUEUE_AW-1:0]  rd_ptr_q;
  logic [QUEUE_CW-1:0]  cnt_q;
  logic [QUEUE_CW-1:0]  cnt_d;

  assign full_o  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QUEUE_CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QUEUE_CW'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  `I2P_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o)
  `I2P_ASSERT_IMP(a_empty_ptrs, clk_i, rst_ni, empty_o, wr_ptr_q == rd_ptr_q)
  `I2P_ASSERT_NXT(a_push_fills, clk_i, rst_ni, push_i && !pop_i, !empty_o)

endmodule

`default_nettype wire

[hdl/i2p_back.sv]
// ----------------------------------------------------------------------------
// i2p_back
// Stack engine: runs one queued item at a time, one pop or push a cycle while its output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "infix_to_postfix_converter_unit_macros.svh"

module i2p_back import i2p_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_empty_i,
  input  wire item_t   q_head_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      out_result_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FullCount = CW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e          state_q, state_d;
  item_t           cur_q;
  logic [CW-1:0]   cnt_q, cnt_d, cnt_dec;
  logic [AW-1:0]   rd_addr;
  opcode_e         stack_mem [STACK_DEPTH];
  opcode_e         top_q;
  result_t         pend_q, pend_d;
  logic            pend_v_q, pend_v_d;
  result_t         out_q, out_d;
  logic            out_v_q, out_v_d;

  logic    stack_empty, stack_full;
  logic    res_v, item_done, do_push, do_pop;
  result_t res;
  logic    out_free, step_go, load_item, ld_out, push_en, pop_en;

  assign stack_empty = (cnt_q == '0);
  assign stack_full  = (cnt_q == FullCount);

  // one step of the current item
  always_comb begin
    res       = '0;
    res_v     = 1'b0;
    item_done = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    unique case (cur_q.kind)
      KIND_FIN: begin
        res_v            = 1'b1;
        res.symbol_valid = 1'b1;
        if (!stack_empty) begin
          res.symbol = op_char(top_q);
          do_pop     = 1'b1;
        end else begin
          res.symbol = CHR_HASH;
          item_done  = 1'b1;
        end
      end
      KIND_DIGIT: begin
        res_v            = 1'b1;
        res.symbol       = cur_q.symbol;
        res.symbol_valid = 1'b1;
        item_done        = 1'b1;
      end
      KIND_LPAR: begin
        item_done = 1'b1;
        if (stack_full) begin
          res_v          = 1'b1;
          res.error_code = ERR_OVERFLOW;
        end else begin
          do_push = 1'b1;
        end
      end
      KIND_RPAR: begin
        if (stack_empty) begin
          res_v          = 1'b1;
          res.error_code = ERR_UNMATCHED;
          item_done      = 1'b1;
        end else if (top_q == OPC_LPAR) begin
          do_pop    = 1'b1;
          item_done = 1'b1;
        end else begin
          res_v            = 1'b1;
          res.symbol       = op_char(top_q);
          res.symbol_valid = 1'b1;
          do_pop           = 1'b1;
        end
      end
      KIND_OPER: begin
        if (!stack_empty && op_prio(top_q) >= op_prio(cur_q.opcode)) begin
          res_v            = 1'b1;
          res.symbol       = op_char(top_q);
          res.symbol_valid = 1'b1;
          do_pop           = 1'b1;
        end else begin
          item_done = 1'b1;
          if (stack_full) begin
            res_v          = 1'b1;
            res.error_code = ERR_OVERFLOW;
          end else begin
            do_push = 1'b1;
          end
        end
      end
      default: item_done = 1'b1;
    endcase
    res.last = item_done;
  end

  // handshake helpers
  assign out_free  = !out_v_q || !out_stall_i;
  assign step_go   = (state_q == ST_RUN) && (!pend_v_q || out_free);
  assign load_item = !q_empty_i &&
                     ((state_q == ST_IDLE) || ((state_q == ST_FLUSH) && out_free));
  assign q_pop_o   = load_item;
  assign push_en   = step_go && do_push;
  assign pop_en    = step_go && do_pop;

  // sequencer: one result held back so the final one can be marked
  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    ld_out   = 1'b0;
    out_d    = pend_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (step_go) begin
          if (res_v) begin
            ld_out   = pend_v_q;
            pend_d   = res;
            pend_v_d = 1'b1;
            if (item_done) state_d = ST_FLUSH;
          end else if (item_done) begin
            ld_out     = pend_v_q;
            out_d.last = 1'b1;
            pend_v_d   = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          ld_out   = 1'b1;
          pend_v_d = 1'b0;
          state_d  = q_empty_i ? ST_IDLE : ST_RUN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_v_d = out_v_q;
    if (ld_out) begin
      out_v_d = 1'b1;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  // stack depth and the address of the next top
  always_comb begin
    cnt_d = cnt_q;
    if (push_en) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_en) begin
      cnt_d = cnt_q - CW'(1);
    end
    cnt_dec = cnt_d - CW'(1);
    rd_addr = (cnt_d == '0) ? '0 : cnt_dec[AW-1:0];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load_item) cur_q <= q_head_i;
    pend_q <= pend_d;
    if (ld_out) out_q <= out_d;
  end

  // operator stack memory, top read registered with write forwarding
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[cnt_q[AW-1:0]] <= cur_q.opcode;
      top_q                    <= cur_q.opcode;
    end else begin
      top_q <= stack_mem[rd_addr];
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_result_o = out_q;

  `I2P_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= FullCount)
  `I2P_ASSERT_IMP(a_flush_final, clk_i, rst_ni, state_q == ST_FLUSH, pend_v_q && pend_q.last)
  `I2P_ASSERT_IMP(a_idle_clean, clk_i, rst_ni, state_q == ST_IDLE, !pend_v_q)
  `I2P_ASSERT_IMP(a_out_free, clk_i, rst_ni, ld_out, out_free)

endmodule

`default_nettype wire

[hdl/infix_to_postfix_converter_unit.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter from infix characters to postfix characters.
// ----------------------------------------------------------------------------
// Input channel: one beat per character (symbol_i) or an end marker
// (finish_i = 1). Characters other than digits, parentheses and * / + -
// are accepted and dropped. Output channel: one beat per result with
// out_symbol_o, symbol_valid_o, error_code_o and last_of_run_o; the last
// result caused by an input beat carries last_of_run_o = 1, and finish
// ends with '#'. Inputs that only push give no output beat.
// Throughput: a four-entry queue decouples the classifier from the stack
// engine; the engine runs one item at a time and pops one operator off
// the stack per step, since the stack memory gives one read a cycle.
// Reset empties the queue, the stack and the output register; the stack
// memory needs no clearing pass. When the receiver stalls the output beat
// holds, the engine stops once its held-back result is full, and input
// stalls once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_unit import i2p_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] symbol_i,
  input  wire logic       finish_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_symbol_o,
  output logic            symbol_valid_o,
  output logic [1:0]      error_code_o,
  output logic            last_of_run_o
);

  logic    q_full, q_push, q_empty, q_pop;
  item_t   q_item, q_head;
  result_t result;

  // classifier
  i2p_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .symbol_i   (symbol_i),
    .finish_i   (finish_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_item)
  );

  // decoupling queue
  i2p_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // stack engine
  i2p_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (result)
  );

  // result fields
  assign out_symbol_o   = result.symbol;
  assign symbol_valid_o = result.symbol_valid;
  assign error_code_o   = result.error_code;
  assign last_of_run_o  = result.last;

endmodule

`default_nettype wire

[bench/infix_to_postfix_converter_unit_checker.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_checker
// Watches both channels of the converter, runs its own shunting-yard stack on
// every accepted input beat and compares each output beat, field by field,
// with the oldest predicted postfix beat.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_unit_checker import i2p_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] symbol_i,
  input  wire logic       finish_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] out_symbol_i,
  input  wire logic       symbol_valid_i,
  input  wire logic [1:0] error_code_i,
  input  wire logic       last_of_run_i,
  output int              fail_count_o,
  output int              pending_o
);

  // predicted operator stack and postfix beats still to come
  opcode_e     op_stack [STACK_DEPTH];
  int unsigned op_depth = 0;
  result_t     postfix_q [$];
  int          fail_count = 0;
  int          pending = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // one line per mismatch
  task report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  // binding strength of a stacked entry
  function automatic int rank_of(opcode_e op);
    case (op)
      OPC_MUL, OPC_DIV: return 4;
      OPC_ADD, OPC_SUB: return 3;
      default:          return 2;
    endcase
  endfunction

  // character that a popped entry turns into
  function automatic logic [7:0] glyph_of(opcode_e op);
    case (op)
      OPC_MUL: return CHR_MUL;
      OPC_DIV: return CHR_DIV;
      OPC_ADD: return CHR_ADD;
      OPC_SUB: return CHR_SUB;
      default: return CHR_LPAR;
    endcase
  endfunction

  function void add_postfix(logic [7:0] sym, logic sym_ok, logic [1:0] err);
    result_t r;
    r.symbol       = sym;
    r.symbol_valid = sym_ok;
    r.error_code   = err;
    r.last         = 1'b0;
    postfix_q.push_back(r);
  endfunction

  function void pop_to_postfix();
    op_depth--;
    add_postfix(glyph_of(op_stack[op_depth]), 1'b1, ERR_NONE);
  endfunction

  // push, or report a full stack by returning 0
  function bit push_op(opcode_e op);
    if (op_depth >= STACK_DEPTH) begin
      return 1'b0;
    end
    op_stack[op_depth] = op;
    op_depth++;
    return 1'b1;
  endfunction

  // one input beat through the shunting-yard algorithm
  function void shunt_symbol(logic [7:0] sym, logic fin);
    int      first;
    opcode_e code;
    bit      is_op;
    bit      matched;
    first   = postfix_q.size();
    code    = OPC_LPAR;
    is_op   = 1'b0;
    matched = 1'b0;
    if (fin) begin
      while (op_depth > 0) pop_to_postfix();
      add_postfix(CHR_HASH, 1'b1, ERR_NONE);
    end else if (sym >= CHR_ZERO && sym <= CHR_NINE) begin
      add_postfix(sym, 1'b1, ERR_NONE);
    end else if (sym == CHR_LPAR) begin
      if (!push_op(OPC_LPAR)) add_postfix(8'h00, 1'b0, ERR_OVERFLOW);
    end else if (sym == CHR_RPAR) begin
      // unwind to the matching open parenthesis
      while (op_depth > 0 && !matched) begin
        if (op_stack[op_depth - 1] == OPC_LPAR) begin
          op_depth--;
          matched = 1'b1;
        end else begin
          pop_to_postfix();
        end
      end
      if (!matched) add_postfix(8'h00, 1'b0, ERR_UNMATCHED);
    end else begin
      case (sym)
        CHR_MUL: begin code = OPC_MUL; is_op = 1'b1; end
        CHR_DIV: begin code = OPC_DIV; is_op = 1'b1; end
        CHR_ADD: begin code = OPC_ADD; is_op = 1'b1; end
        CHR_SUB: begin code = OPC_SUB; is_op = 1'b1; end
        default: is_op = 1'b0;
      endcase
      if (is_op) begin
        // pop everything that binds at least as tightly
        while (op_depth > 0 && rank_of(op_stack[op_depth - 1]) >= rank_of(code)) begin
          pop_to_postfix();
        end
        if (!push_op(code)) add_postfix(8'h00, 1'b0, ERR_OVERFLOW);
      end
    end
    // flag the final beat of this run
    if (postfix_q.size() > first) begin
      postfix_q[postfix_q.size() - 1].last = 1'b1;
    end
  endfunction

  // compare output beats first, then predict from the input beat
  always @(posedge clk_i) begin : watch
    result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (postfix_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, symbol %h error %0d",
                                    out_symbol_i, error_code_i));
        end else begin
          want = postfix_q.pop_front();
          if (out_symbol_i !== want.symbol) begin
            report_mismatch($sformatf("out_symbol %h, want %h", out_symbol_i, want.symbol));
          end
          if (symbol_valid_i !== want.symbol_valid) begin
            report_mismatch($sformatf("symbol_valid %b, want %b",
                                      symbol_valid_i, want.symbol_valid));
          end
          if (error_code_i !== want.error_code) begin
            report_mismatch($sformatf("error_code %0d, want %0d",
                                      error_code_i, want.error_code));
          end
          if (last_of_run_i !== want.last) begin
            report_mismatch($sformatf("last_of_run %b, want %b", last_of_run_i, want.last));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        shunt_symbol(symbol_i, finish_i);
      end
      pending = postfix_q.size();
    end
  end

endmodule

`default_nettype wire

[bench/infix_to_postfix_converter_unit_test.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_test
// Feeds directed and random infix character streams into the converter under
// three idle patterns and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_unit_test;
  import i2p_pkg::*;

  localparam int unsigned STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int          FEED_TOTAL  = 410;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] symbol_i    = 8'h00;
  logic       finish_i    = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_symbol_o;
  logic       symbol_valid_o;
  logic [1:0] error_code_o;
  logic       last_of_run_o;

  int fail_count;
  int expected_left;
  int fed_count         = 0;
  int sender_idle_pct   = 12;
  int receiver_idle_pct = 71;

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .symbol_i      (symbol_i),
    .finish_i      (finish_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_symbol_o  (out_symbol_o),
    .symbol_valid_o(symbol_valid_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

  infix_to_postfix_converter_unit_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) postfix_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .symbol_i      (symbol_i),
    .finish_i      (finish_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_symbol_i  (out_symbol_o),
    .symbol_valid_i(symbol_valid_o),
    .error_code_i  (error_code_o),
    .last_of_run_i (last_of_run_o),
    .fail_count_o  (fail_count),
    .pending_o     (expected_left)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
  end

  function automatic bit is_handled(logic [7:0] sym);
    return (sym >= CHR_ZERO && sym <= CHR_NINE) || sym == CHR_LPAR || sym == CHR_RPAR ||
           sym == CHR_MUL || sym == CHR_DIV || sym == CHR_ADD || sym == CHR_SUB;
  endfunction

  function automatic logic [7:0] random_digit();
    return CHR_ZERO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(3))
      0:       return CHR_MUL;
      1:       return CHR_DIV;
      2:       return CHR_ADD;
      default: return CHR_SUB;
    endcase
  endfunction

  // one input beat, with a random gap in front, held until taken
  task automatic send_symbol(input logic [7:0] sym, input logic fin);
    bit taken;
    if (fed_count < FEED_TOTAL / 3) begin
      sender_idle_pct   = 12;
      receiver_idle_pct = 71;
    end else if (fed_count < 2 * FEED_TOTAL / 3) begin
      sender_idle_pct   = 71;
      receiver_idle_pct = 12;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    finish_i   <= fin;
    taken = 1'b0;
    // stall is settled by the falling edge
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    if (fin || is_handled(sym)) fed_count++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_symbol(8'(s[i]), 1'b0);
  endtask

  // well-formed expression with random nesting, closed by finish
  task automatic send_expression();
    int terms;
    int opens;
    int closes;
    int t;
    opens = 0;
    terms = $urandom_range(6, 1);
    for (t = 0; t < terms; t++) begin
      if (t > 0) send_symbol(random_operator(), 1'b0);
      while (opens < 4 && $urandom_range(3) == 0) begin
        send_symbol(CHR_LPAR, 1'b0);
        opens++;
      end
      send_symbol(random_digit(), 1'b0);
      if (opens > 0) begin
        closes = $urandom_range(opens);
        repeat (closes) send_symbol(CHR_RPAR, 1'b0);
        opens -= closes;
      end
    end
    repeat (opens) send_symbol(CHR_RPAR, 1'b0);
    send_symbol(8'($urandom_range(255)), 1'b1);
  endtask

  // arbitrary bytes, now and then a finish
  task automatic send_noise();
    repeat ($urandom_range(4, 1)) begin
      send_symbol(8'($urandom_range(255)), ($urandom_range(7) == 0));
    end
  endtask

  // random tokens with no regard for balance
  task automatic send_broken();
    repeat ($urandom_range(8, 2)) begin
      case ($urandom_range(3))
        0:       send_symbol(random_digit(), 1'b0);
        1:       send_symbol(CHR_LPAR, 1'b0);
        2:       send_symbol(CHR_RPAR, 1'b0);
        default: send_symbol(random_operator(), 1'b0);
      endcase
    end
    if ($urandom_range(1) == 0) send_symbol(8'($urandom_range(255)), 1'b1);
  endtask

  // nest to around the stack depth, push once more, then drain on finish
  task automatic send_deep_nest();
    repeat ($urandom_range(STACK_DEPTH + 2, STACK_DEPTH - 2)) begin
      if ($urandom_range(3) != 0) begin
        send_symbol(CHR_LPAR, 1'b0);
      end else begin
        send_symbol(random_digit(), 1'b0);
        send_symbol(($urandom_range(1) == 0) ? CHR_ADD : CHR_SUB, 1'b0);
      end
    end
    send_symbol(($urandom_range(1) == 0) ? CHR_LPAR : random_operator(), 1'b0);
    send_symbol(random_digit(), 1'b0);
    send_symbol(8'($urandom_range(255)), 1'b1);
  endtask

  // stimulus
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: mixed priorities with nesting
    send_text("0+9*(1-2)/3");
    send_symbol(8'h00, 1'b1);
    // unmatched close on an empty stack
    send_text(")");
    // operator inside parentheses, hash ignored
    send_text("(*#)");
    // unmatched close after a pending operator
    send_text("5-)");
    // open parenthesis left at finish
    send_text("(");
    send_symbol(8'hFF, 1'b1);
    // ignored extremes, then finish on an empty stack
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(CHR_ZERO, 1'b1);

    // random
    send_deep_nest();
    while (fed_count < FEED_TOTAL) begin
      case ($urandom_range(99)) inside
        [0:74]:  send_expression();
        [75:84]: send_noise();
        [85:95]: send_broken();
        default: send_deep_nest();
      endcase
    end
    in_valid_i <= 1'b0;

    // drain
    do @(negedge clk_i); while (expected_left != 0);
    repeat (24) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("infix_to_postfix_converter_unit verification clean");
    end else begin
      $display("infix_to_postfix_converter_unit verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("infix_to_postfix_converter_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire
